>>> src/ntc_pkg.sv
package ntc_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   typedef enum logic [2:0] {
      CLS_INT  = 3'd0,
      CLS_SINT = 3'd1,
      CLS_DEC  = 3'd2,
      CLS_SDEC = 3'd3,
      CLS_HEX  = 3'd4,
      CLS_ERR  = 3'd5
   } token_class_type;

   typedef enum logic [3:0] {
      CK_NUL    = 4'd0,
      CK_SPACE  = 4'd1,
      CK_SIGN   = 4'd2,
      CK_ZERO   = 4'd3,
      CK_NZ     = 4'd4,
      CK_COMMA  = 4'd5,
      CK_X      = 4'd6,
      CK_HEXLET = 4'd7,
      CK_OTHER  = 4'd8
   } char_kind_type;

   typedef enum logic [13:0] {
      ST_IDLE    = 14'h0001,
      ST_SIGN    = 14'h0002,
      ST_INT     = 14'h0004,
      ST_INTZ    = 14'h0008,
      ST_SINT    = 14'h0010,
      ST_COMMA   = 14'h0020,
      ST_DEC     = 14'h0040,
      ST_SCOMMA  = 14'h0080,
      ST_SDEC    = 14'h0100,
      ST_ZERO    = 14'h0200,
      ST_HEXP    = 14'h0400,
      ST_HEX     = 14'h0800,
      ST_SZERO   = 14'h1000,
      ST_SWALLOW = 14'h2000
   } scan_state_type;

   typedef struct packed {
      token_class_type token_class;
      logic            string_end;
   } token_result_type;

   typedef struct packed {
      logic             push;
      token_result_type result;
      logic             idle;
   } front_status_type;

   function automatic char_kind_type classify_char(input logic [7:0] c);
      char_kind_type kind;
      if (c == CH_NUL)
         kind = CK_NUL;
      else if (c == CH_SPACE)
         kind = CK_SPACE;
      else if (c == CH_PLUS || c == CH_MINUS)
         kind = CK_SIGN;
      else if (c == CH_ZERO)
         kind = CK_ZERO;
      else if (c inside {[8'h31:8'h39]})
         kind = CK_NZ;
      else if (c == CH_COMMA)
         kind = CK_COMMA;
      else if (c == CH_LX || c == CH_UX)
         kind = CK_X;
      else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
         kind = CK_HEXLET;
      else
         kind = CK_OTHER;
      return kind;
   endfunction

endpackage

>>> src/numeric_token_classifier_unit.sv
// Numeric token classifier.
// req channel: one character byte per request on req_char_byte. Bytes form
// tokens separated by space (0x20); NUL (0x00) ends a token and the string.
// rsp channel: one result per token, rsp_token_class (0 integer, 1 signed
// integer, 2 decimal, 3 signed decimal, 4 hex, 5 error) and rsp_string_end
// set when NUL closed the token. Delimiters between tokens give no result.
// A request is taken when valid is high and stall is low on its channel.
// Throughput: one request per cycle while req_stall is low; the scanner
// state update is a combinational next-state function. A result is written
// into the result queue at the edge that takes the delimiter request, and
// from there moves into the output register that drives rsp_valid.
// When the receiver stalls, results collect in the QUEUE_DEPTH-entry queue;
// req_stall rises only while that queue is full.
// Reset (synchronous, active high) returns the scanner to idle between
// tokens and empties the queue and the output register.
module numeric_token_classifier_unit
   import ntc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_class,
   output logic       rsp_string_end
);

   logic             req_accept;
   front_status_type fr_status;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   token_result_type q_data;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   ntc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_byte (req_char_byte),
      .status    (fr_status)
   );

   ntc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_status.push),
      .push_data (fr_status.result),
      .pop       (q_pop),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   ntc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_class (rsp_token_class),
      .rsp_string_end  (rsp_string_end)
   );

   a_push_on_delim: assert property (@(posedge clock) disable iff (reset)
      fr_status.push |-> (req_accept && (req_char_byte == CH_NUL ||
                                         req_char_byte == CH_SPACE)))
      else $error("result pushed without a delimiter request");

   a_idle_after_delim: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_char_byte == CH_NUL || req_char_byte == CH_SPACE))
      |=> fr_status.idle)
      else $error("scanner not idle after delimiter");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_class <= 3'(CLS_ERR)))
      else $error("result class out of range");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty result queue");

endmodule

>>> src/ntc_front.sv
module ntc_front
   import ntc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       char_byte,
   output front_status_type status
);

   scan_state_type   state_ff;
   scan_state_type   state_in;
   char_kind_type    kind;
   logic             delim;
   logic             digit;
   token_class_type  cls;

   assign kind  = classify_char(char_byte);
   assign delim = (kind == CK_NUL) || (kind == CK_SPACE);
   assign digit = (kind == CK_ZERO) || (kind == CK_NZ);

   // class reported when a delimiter closes the current token
   always_comb begin
      case (state_ff)
         ST_INT, ST_INTZ, ST_ZERO: cls = CLS_INT;
         ST_SINT:                  cls = CLS_SINT;
         ST_DEC:                   cls = CLS_DEC;
         ST_SDEC:                  cls = CLS_SDEC;
         ST_HEX:                   cls = CLS_HEX;
         default:                  cls = CLS_ERR;
      endcase
   end

   always_comb begin
      state_in = ST_SWALLOW;
      if (delim) begin
         state_in = ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (kind == CK_SIGN)      state_in = ST_SIGN;
               else if (kind == CK_NZ)   state_in = ST_INT;
               else if (kind == CK_ZERO) state_in = ST_ZERO;
            end
            ST_SIGN: begin
               if (kind == CK_NZ)        state_in = ST_SINT;
               else if (kind == CK_ZERO) state_in = ST_SZERO;
            end
            ST_INT: begin
               if (digit)                 state_in = ST_INT;
               else if (kind == CK_COMMA) state_in = ST_COMMA;
            end
            ST_INTZ: begin
               if (digit) state_in = ST_INTZ;
            end
            ST_SINT: begin
               if (digit)                 state_in = ST_SINT;
               else if (kind == CK_COMMA) state_in = ST_SCOMMA;
            end
            ST_COMMA, ST_DEC: begin
               if (digit) state_in = ST_DEC;
            end
            ST_SCOMMA, ST_SDEC: begin
               if (digit) state_in = ST_SDEC;
            end
            ST_ZERO: begin
               if (kind == CK_X)          state_in = ST_HEXP;
               else if (kind == CK_COMMA) state_in = ST_COMMA;
               else if (digit)            state_in = ST_INTZ;
            end
            ST_HEXP, ST_HEX: begin
               if (digit || kind == CK_HEXLET) state_in = ST_HEX;
            end
            ST_SZERO: begin
               if (kind == CK_COMMA) state_in = ST_SCOMMA;
            end
            default: state_in = ST_SWALLOW;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else if (accept)
         state_ff <= state_in;
   end

   assign status.push               = accept && delim && (state_ff != ST_IDLE);
   assign status.result.token_class = cls;
   assign status.result.string_end  = (kind == CK_NUL);
   assign status.idle               = (state_ff == ST_IDLE);

endmodule

>>> src/ntc_queue.sv
module ntc_queue
   import ntc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  token_result_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             pop_valid,
   output token_result_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> src/ntc_back.sv
module ntc_back
   import ntc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  token_result_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_token_class,
   output logic             rsp_string_end
);

   logic             out_valid_ff, out_valid_in;
   token_result_type out_data_ff;

   // advance whenever the output register is empty or being taken
   assign q_pop        = q_valid && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = q_pop || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop)
         out_data_ff <= q_data;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_token_class = out_data_ff.token_class;
   assign rsp_string_end  = out_data_ff.string_end;

endmodule

>>> verif/numeric_token_classifier_unit_tb.sv
`timescale 1ns / 1ps

module numeric_token_classifier_unit_tb;
   import ntc_pkg::*;

   localparam logic [3:0] SC_IDLE    = 4'd0;
   localparam logic [3:0] SC_SIGN    = 4'd1;
   localparam logic [3:0] SC_INT     = 4'd2;
   localparam logic [3:0] SC_INTZ    = 4'd3;
   localparam logic [3:0] SC_SINT    = 4'd4;
   localparam logic [3:0] SC_COMMA   = 4'd5;
   localparam logic [3:0] SC_DEC     = 4'd6;
   localparam logic [3:0] SC_SCOMMA  = 4'd7;
   localparam logic [3:0] SC_SDEC    = 4'd8;
   localparam logic [3:0] SC_ZERO    = 4'd9;
   localparam logic [3:0] SC_HEXP    = 4'd10;
   localparam logic [3:0] SC_HEX     = 4'd11;
   localparam logic [3:0] SC_SZERO   = 4'd12;
   localparam logic [3:0] SC_SWALLOW = 4'd13;

   typedef struct {
      logic [3:0]       next;
      logic             emit;
      token_result_type result;
   } scan_step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_token_class;
   logic       rsp_string_end;

   logic [7:0]       char_queue[$];
   token_result_type token_expect[$];
   logic [3:0]       scan_state = SC_IDLE;
   scan_step_type    step;
   logic             req_taken = 1'b0;
   int               reqs_outstanding = 0;
   int               send_idle_pct = 20;
   int               rsp_idle_pct = 52;
   int               rsp_hold_left = 0;
   int               errors = 0;
   int               target;
   string            hex_set = "0123456789abcdefABCDEF";

   numeric_token_classifier_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_byte  (req_char_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_class(rsp_token_class),
      .rsp_string_end (rsp_string_end)
   );

   always #4 clock = ~clock;

   function automatic scan_step_type scan_char(logic [3:0] st, logic [7:0] c);
      scan_step_type r;
      logic          digit;
      logic          nz;
      digit = (c >= CH_ZERO) && (c <= 8'h39);
      nz    = digit && (c != CH_ZERO);
      r.next = SC_SWALLOW;
      r.emit = 1'b0;
      r.result.token_class = CLS_ERR;
      r.result.string_end  = (c == CH_NUL);
      if (c == CH_NUL || c == CH_SPACE) begin
         r.emit = (st != SC_IDLE);
         r.next = SC_IDLE;
         case (st)
            SC_INT, SC_INTZ, SC_ZERO: r.result.token_class = CLS_INT;
            SC_SINT: r.result.token_class = CLS_SINT;
            SC_DEC:  r.result.token_class = CLS_DEC;
            SC_SDEC: r.result.token_class = CLS_SDEC;
            SC_HEX:  r.result.token_class = CLS_HEX;
            default: r.result.token_class = CLS_ERR;
         endcase
      end else begin
         case (st)
            SC_IDLE: begin
               if (c == CH_PLUS || c == CH_MINUS) r.next = SC_SIGN;
               else if (nz)                       r.next = SC_INT;
               else if (c == CH_ZERO)             r.next = SC_ZERO;
            end
            SC_SIGN: begin
               if (nz)                 r.next = SC_SINT;
               else if (c == CH_ZERO)  r.next = SC_SZERO;
            end
            SC_INT: begin
               if (digit)              r.next = SC_INT;
               else if (c == CH_COMMA) r.next = SC_COMMA;
            end
            SC_INTZ: begin
               if (digit) r.next = SC_INTZ;
            end
            SC_SINT: begin
               if (digit)              r.next = SC_SINT;
               else if (c == CH_COMMA) r.next = SC_SCOMMA;
            end
            SC_COMMA, SC_DEC: begin
               if (digit) r.next = SC_DEC;
            end
            SC_SCOMMA, SC_SDEC: begin
               if (digit) r.next = SC_SDEC;
            end
            SC_ZERO: begin
               if (c == CH_LX || c == CH_UX) r.next = SC_HEXP;
               else if (c == CH_COMMA)       r.next = SC_COMMA;
               else if (digit)               r.next = SC_INTZ;
            end
            SC_HEXP, SC_HEX: begin
               if (digit || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                  r.next = SC_HEX;
            end
            SC_SZERO: begin
               if (c == CH_COMMA) r.next = SC_SCOMMA;
            end
            default: r.next = SC_SWALLOW;
         endcase
      end
      return r;
   endfunction

   task automatic push_byte(logic [7:0] b);
      char_queue.push_back(b);
      reqs_outstanding++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_digits(int n);
      for (int i = 0; i < n; i++) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_nz();
      push_byte(CH_ZERO + 8'($urandom_range(1, 9)));
   endtask

   task automatic push_sign();
      push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
   endtask

   task automatic push_random_token();
      int n;
      case ($urandom_range(0, 9))
         0: begin
            push_nz();
            push_digits($urandom_range(0, 4));
         end
         1: begin
            push_byte(CH_ZERO);
            push_digits($urandom_range(0, 3));
         end
         2: begin
            push_sign();
            push_nz();
            push_digits($urandom_range(0, 3));
         end
         3: begin
            push_nz();
            push_digits($urandom_range(0, 2));
            push_byte(CH_COMMA);
            push_digits($urandom_range(1, 3));
         end
         4: begin
            push_byte(CH_ZERO);
            push_byte(CH_COMMA);
            push_digits($urandom_range(1, 3));
         end
         5: begin
            push_sign();
            if ($urandom_range(0, 1)) begin
               push_nz();
               push_digits($urandom_range(0, 2));
            end else begin
               push_byte(CH_ZERO);
            end
            push_byte(CH_COMMA);
            push_digits($urandom_range(1, 3));
         end
         6: begin
            push_byte(CH_ZERO);
            push_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_byte(hex_set[$urandom_range(0, 21)]);
         end
         7: begin
            // incomplete or malformed shapes
            case ($urandom_range(0, 5))
               0: push_sign();
               1: begin
                  push_nz();
                  push_byte(CH_COMMA);
               end
               2: begin
                  push_byte(CH_ZERO);
                  push_byte(CH_LX);
               end
               3: begin
                  push_sign();
                  push_byte(CH_ZERO);
               end
               4: push_text("00,5");
               default: begin
                  push_sign();
                  push_byte(CH_COMMA);
               end
            endcase
         end
         8: begin
            push_nz();
            push_byte(8'($urandom_range(1, 255)));
            push_digits(1);
         end
         default: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
         end
      endcase
      case ($urandom_range(0, 9))
         0: push_byte(CH_NUL);
         1: push_text("  ");
         default: push_byte(CH_SPACE);
      endcase
   endtask

   task automatic drain();
      while (reqs_outstanding != 0) @(posedge clock);
      while (token_expect.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_char_byte <= char_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // monitor: predict on each request taken, check each response taken
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         step       = scan_char(scan_state, req_char_byte);
         scan_state = step.next;
         if (step.emit) token_expect.push_back(step.result);
         reqs_outstanding--;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_expect.size() == 0) begin
            $display("%0t: unexpected result, actual class %0d string_end %0b",
                     $time, rsp_token_class, rsp_string_end);
            errors++;
         end else begin
            if (rsp_token_class != token_expect[0].token_class) begin
               $display("%0t: token_class mismatch, expected %0d, actual %0d",
                        $time, token_expect[0].token_class, rsp_token_class);
               errors++;
            end
            if (rsp_string_end != token_expect[0].string_end) begin
               $display("%0t: string_end mismatch, expected %0b, actual %0b",
                        $time, token_expect[0].string_end, rsp_string_end);
               errors++;
            end
            void'(token_expect.pop_front());
         end
      end
   end

   initial begin
      #500000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: idle delimiter, incomplete tokens, swallowing, each class
      push_text(" + 1, 0x ");
      push_text("-0");
      push_byte(CH_NUL);
      push_byte(8'hFF);
      push_byte(CH_SPACE);
      push_text("+0,9 00 5,0 -9 ");
      push_text("0XaF");
      push_byte(CH_NUL);
      drain();

      // hold the receiver off so the result queue fills and stalls requests
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_hold_left = 80;
      for (int i = 0; i < 30; i++) begin
         push_nz();
         push_byte(CH_SPACE);
      end
      drain();

      send_idle_pct = 20;
      rsp_idle_pct  = 52;
      target = reqs_outstanding + 135;
      while (reqs_outstanding < target) push_random_token();
      drain();

      send_idle_pct = 52;
      rsp_idle_pct  = 20;
      target = reqs_outstanding + 135;
      while (reqs_outstanding < target) push_random_token();
      drain();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      target = reqs_outstanding + 135;
      while (reqs_outstanding < target) push_random_token();
      drain();

      repeat (10) @(posedge clock);
      if (errors == 0 && token_expect.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ntc_pkg.sv
src/ntc_front.sv
src/ntc_queue.sv
src/ntc_back.sv
src/numeric_token_classifier_unit.sv
verif/numeric_token_classifier_unit_tb.sv
